// ----- rtl/himm_pkg.sv -----
// Shared types and constants for the hit ID multiset matcher.
`default_nettype none
package himm_pkg;

  localparam int NUM_IDS  = 256;
  localparam int ID_W     = $clog2(NUM_IDS);
  localparam int MAX_HITS = 32;
  localparam int CNT_W    = $clog2(MAX_HITS + 1);
  localparam int TOTAL_W  = 32;
  localparam int CMD_W    = 2;

  // Command codes on the input channel; the fourth code is unused
  typedef enum logic [CMD_W-1:0] {
    CMD_PRIMARY   = 2'd0,
    CMD_SECONDARY = 2'd1,
    CMD_CLOSE     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CLOSE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic close;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/himm_ctrl.sv -----
// Controller state machine for the hit ID multiset matcher.
`default_nettype none
module himm_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [himm_pkg::CMD_W-1:0] command,
  output logic                          busy,
  output himm_pkg::ctrl_cmd_t           ctrl
);
  import himm_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the accepted command and sequence the datapath
  always_comb begin
    state_next   = state;
    ctrl.capture = 1'b0;
    ctrl.update  = 1'b0;
    ctrl.close   = 1'b0;
    busy         = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (command) inside
            CMD_PRIMARY, CMD_SECONDARY: begin
              ctrl.capture = 1'b1;
              state_next   = ST_UPDATE;
            end
            CMD_CLOSE: begin
              state_next = ST_CLOSE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_CLOSE: begin
        ctrl.close = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/himm_datapath.sv -----
// Datapath: per-ID count table, event flags, totals and result registers.
`default_nettype none
module himm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  himm_pkg::ctrl_cmd_t              ctrl,
  input  wire logic [himm_pkg::CMD_W-1:0]  command,
  input  wire logic [himm_pkg::ID_W-1:0]   detector_id,
  output logic                             done,
  output logic [himm_pkg::CNT_W-1:0]       extra_secondary_count,
  output logic                             repeated_primary,
  output logic [himm_pkg::TOTAL_W-1:0]     events_total,
  output logic [himm_pkg::TOTAL_W-1:0]     repeated_events_total
);
  import himm_pkg::*;

  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_HITS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [CNT_W-1:0]   count_mem [NUM_IDS];
  logic [NUM_IDS-1:0] entry_valid;

  logic               hit_primary;
  logic [ID_W-1:0]    hit_id;
  logic [CNT_W-1:0]   rd_data;
  logic               rd_valid;
  logic [CNT_W-1:0]   cur_count;
  logic [CNT_W-1:0]   new_count;
  logic               write_en;

  logic [CNT_W-1:0]   extra_count;
  logic               repeat_flag;
  logic [TOTAL_W-1:0] event_counter;
  logic [TOTAL_W-1:0] repeat_event_counter;
  logic [TOTAL_W-1:0] event_counter_next;
  logic [TOTAL_W-1:0] repeat_event_counter_next;

  // Capture the hit and read its table entry
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit_primary <= (command == CMD_PRIMARY);
      hit_id      <= detector_id;
      rd_data     <= count_mem[detector_id];
      rd_valid    <= entry_valid[detector_id];
    end
  end

  // An entry not written in this event reads as zero
  assign cur_count = rd_valid ? rd_data : '0;

  // Work out the new count for the hit
  always_comb begin
    new_count = cur_count;
    write_en  = 1'b0;
    if (hit_primary) begin
      write_en = 1'b1;
      if (cur_count != CNT_MAX) begin
        new_count = cur_count + CNT_W'(1);
      end
    end else if (cur_count != '0) begin
      write_en  = 1'b1;
      new_count = cur_count - CNT_W'(1);
    end
  end

  // Write the table entry back
  always_ff @(posedge clk) begin
    if (ctrl.update && write_en) begin
      count_mem[hit_id] <= new_count;
    end
  end

  // Mark written entries; drop them all on reset or close
  always_ff @(posedge clk) begin
    if (rst || ctrl.close) begin
      entry_valid <= '0;
    end else if (ctrl.update && write_en) begin
      entry_valid[hit_id] <= 1'b1;
    end
  end

  // Saturating totals after counting this event
  always_comb begin
    event_counter_next        = event_counter;
    repeat_event_counter_next = repeat_event_counter;
    if (event_counter != TOTAL_MAX) begin
      event_counter_next = event_counter + TOTAL_W'(1);
    end
    if (repeat_flag && (repeat_event_counter != TOTAL_MAX)) begin
      repeat_event_counter_next = repeat_event_counter + TOTAL_W'(1);
    end
  end

  // Advance event flags, extra count and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      extra_count          <= '0;
      repeat_flag          <= 1'b0;
      event_counter        <= '0;
      repeat_event_counter <= '0;
    end else if (ctrl.close) begin
      extra_count          <= '0;
      repeat_flag          <= 1'b0;
      event_counter        <= event_counter_next;
      repeat_event_counter <= repeat_event_counter_next;
    end else if (ctrl.update) begin
      if (hit_primary && (cur_count != '0)) begin
        repeat_flag <= 1'b1;
      end
      if (!hit_primary && (cur_count == '0) && (extra_count != CNT_MAX)) begin
        extra_count <= extra_count + CNT_W'(1);
      end
    end
  end

  // Present the result for one cycle after close
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.close;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.close) begin
      extra_secondary_count <= extra_count;
      repeated_primary      <= repeat_flag;
      events_total          <= event_counter_next;
      repeated_events_total <= repeat_event_counter_next;
    end
  end

  // Table update always follows a capture
  a_update_after_capture: assert property (@(posedge clk) disable iff (rst)
    ctrl.update |-> $past(ctrl.capture))
    else $error("table update without a preceding capture");

  // Results never come in consecutive cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Extra count never passes its ceiling
  a_extra_bound: assert property (@(posedge clk) disable iff (rst)
    extra_count <= CNT_MAX)
    else $error("extra count beyond saturation");

  // Flagged events never outnumber events
  a_totals_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (repeated_events_total <= events_total) && (events_total != '0))
    else $error("inconsistent event totals");

endmodule
`default_nettype wire

// ----- rtl/hit_id_multiset_matcher_core.sv -----
// Top level of the hit ID multiset matcher: controller plus datapath.
//
//  Channel   Handshake              Payload
//  input     start, busy            command, detector_id
//  result    done (one-cycle pulse) extra_secondary_count, repeated_primary,
//                                   events_total, repeated_events_total
//
// A hit reads its table entry when captured and writes it back in the update
// state (single-port count table, registered read). A close passes through
// the close state; its result is registered from it, with done high for one
// cycle. Unused command codes are ignored. Per-ID entries carry valid bits
// that reset and close clear at once, so there is no clearing pass after
// reset. The receiver cannot stall; results are taken as presented.
`default_nettype none
module hit_id_multiset_matcher_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [himm_pkg::CMD_W-1:0]     command,
  input  wire logic [himm_pkg::ID_W-1:0]      detector_id,
  output logic                                done,
  output logic [himm_pkg::CNT_W-1:0]          extra_secondary_count,
  output logic                                repeated_primary,
  output logic [himm_pkg::TOTAL_W-1:0]        events_total,
  output logic [himm_pkg::TOTAL_W-1:0]        repeated_events_total
);
  import himm_pkg::*;

  ctrl_cmd_t ctrl;

  himm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  himm_datapath u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .ctrl                  (ctrl),
    .command               (command),
    .detector_id           (detector_id),
    .done                  (done),
    .extra_secondary_count (extra_secondary_count),
    .repeated_primary      (repeated_primary),
    .events_total          (events_total),
    .repeated_events_total (repeated_events_total)
  );

endmodule
`default_nettype wire

// ----- test/hit_id_multiset_matcher_core_tb.sv -----
// Self-checking testbench for the hit ID multiset matcher core.
`timescale 1ns / 1ps
module hit_id_multiset_matcher_core_tb;
  import himm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
  } hit_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   extra;
    logic               flagged;
    logic [TOTAL_W-1:0] events;
    logic [TOTAL_W-1:0] flagged_events;
  } event_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   command = '0;
  logic [ID_W-1:0]    detector_id = '0;
  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   extra_secondary_count;
  logic               repeated_primary;
  logic [TOTAL_W-1:0] events_total;
  logic [TOTAL_W-1:0] repeated_events_total;

  // Shadow of the block's event state
  logic [CNT_W-1:0]   unmatched_hits [NUM_IDS];
  logic [CNT_W-1:0]   extra_hits;
  logic               repeat_seen;
  logic [TOTAL_W-1:0] closed_events;
  logic [TOTAL_W-1:0] closed_flagged;

  hit_item_t     hit_stream[$];
  event_report_t expected_reports[$];

  int items_queued;
  int items_sent;
  int reports_checked;
  int flagged_checked;
  int saturated_reports;
  int mismatches;
  int cycle_count;

  hit_id_multiset_matcher_core uut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .command               (command),
    .detector_id           (detector_id),
    .done                  (done),
    .extra_secondary_count (extra_secondary_count),
    .repeated_primary      (repeated_primary),
    .events_total          (events_total),
    .repeated_events_total (repeated_events_total)
  );

  always #1 clk = ~clk;

  // Advance the shadow state by one accepted transfer
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    event_report_t rep;
    if (cmd == CMD_PRIMARY) begin
      if (unmatched_hits[id] != '0) repeat_seen = 1'b1;
      if (unmatched_hits[id] < MAX_HITS) unmatched_hits[id] = unmatched_hits[id] + 1'b1;
    end else if (cmd == CMD_SECONDARY) begin
      if (unmatched_hits[id] != '0) unmatched_hits[id] = unmatched_hits[id] - 1'b1;
      else if (extra_hits < MAX_HITS) extra_hits = extra_hits + 1'b1;
    end else if (cmd == CMD_CLOSE) begin
      if (closed_events != TOTAL_SAT) closed_events = closed_events + 1'b1;
      if (repeat_seen && closed_flagged != TOTAL_SAT) closed_flagged = closed_flagged + 1'b1;
      rep.extra          = extra_hits;
      rep.flagged        = repeat_seen;
      rep.events         = closed_events;
      rep.flagged_events = closed_flagged;
      expected_reports.push_back(rep);
      foreach (unmatched_hits[i]) unmatched_hits[i] = '0;
      extra_hits  = '0;
      repeat_seen = 1'b0;
    end
  endtask

  task automatic push_hit(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    hit_item_t it;
    it.cmd = cmd;
    it.id  = id;
    hit_stream.push_back(it);
    items_queued++;
  endtask

  // Well-formed event: primaries, then secondaries partly matching them, then close
  task automatic queue_clean_event();
    logic [ID_W-1:0] used_ids[$];
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] base;
    int n_prim;
    int n_sec;
    bit narrow;
    n_prim = $urandom_range(8);
    n_sec  = $urandom_range(8);
    narrow = 1'($urandom_range(1));
    base   = ID_W'($urandom);
    for (int i = 0; i < n_prim; i++) begin
      id = narrow ? base + ID_W'($urandom_range(3)) : ID_W'($urandom);
      used_ids.push_back(id);
      push_hit(CMD_PRIMARY, id);
    end
    for (int i = 0; i < n_sec; i++) begin
      if (used_ids.size() != 0 && $urandom_range(9) < 7)
        id = used_ids[$urandom_range(used_ids.size() - 1)];
      else
        id = ID_W'($urandom);
      push_hit(CMD_SECONDARY, id);
    end
    push_hit(CMD_CLOSE, ID_W'($urandom));
  endtask

  // Drive one ID near or past the per-ID ceiling, then drain it toward or past empty
  task automatic queue_count_ceiling_event();
    logic [ID_W-1:0] id;
    int n_prim;
    int n_sec;
    id     = ID_W'($urandom);
    n_prim = $urandom_range(36, 30);
    n_sec  = $urandom_range(40, 30);
    repeat (n_prim) push_hit(CMD_PRIMARY, id);
    repeat (n_sec) push_hit(CMD_SECONDARY, id);
    push_hit(CMD_CLOSE, ID_W'($urandom));
  endtask

  // Unmatched secondaries near or past the extra-count ceiling
  task automatic queue_extra_ceiling_event();
    int n_sec;
    n_sec = $urandom_range(40, 30);
    repeat (n_sec) push_hit(CMD_SECONDARY, ID_W'($urandom));
    push_hit(CMD_CLOSE, ID_W'($urandom));
  endtask

  // Unordered commands, including the unused code and primaries after secondaries
  task automatic queue_noise();
    logic [ID_W-1:0] base;
    int n;
    n    = $urandom_range(10, 1);
    base = ID_W'($urandom);
    repeat (n) push_hit(CMD_W'($urandom_range(3)), base + ID_W'($urandom_range(2)));
    if ($urandom_range(1)) push_hit(CMD_CLOSE, ID_W'($urandom));
  endtask

  // Present the next transfer, holding it while busy
  always @(posedge clk) begin : drive_p
    hit_item_t nxt;
    bit quiet;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(command, detector_id);
        items_sent++;
      end
      if (!(start && busy)) begin
        quiet = (items_sent >= 250 && items_sent < 400) ? 1'b0 : ($urandom_range(99) < 6);
        if (hit_stream.size() != 0 && !quiet) begin
          nxt = hit_stream.pop_front();
          start       <= 1'b1;
          command     <= nxt.cmd;
          detector_id <= nxt.id;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_p
    event_report_t want;
    event_report_t got;
    if (!rst && done) begin
      got.extra          = extra_secondary_count;
      got.flagged        = repeated_primary;
      got.events         = events_total;
      got.flagged_events = repeated_events_total;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: extra=%0d flag=%0b events=%0d rep=%0d",
                   got.extra, got.flagged, got.events, got.flagged_events);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (want.flagged) flagged_checked++;
        if (want.extra == MAX_HITS) saturated_reports++;
        if (got.extra !== want.extra || got.flagged !== want.flagged ||
            got.events !== want.events || got.flagged_events !== want.flagged_events) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: report %0d: expected extra=%0d flag=%0b events=%0d rep=%0d",
                     reports_checked, want.extra, want.flagged, want.events,
                     want.flagged_events);
            $display("       got extra=%0d flag=%0b events=%0d rep=%0d",
                     got.extra, got.flagged, got.events, got.flagged_events);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hit_id_multiset_matcher_core test failed");
      $finish;
    end
  end

  initial begin : stimulus_p
    int kind;
    foreach (unmatched_hits[i]) unmatched_hits[i] = '0;
    extra_hits     = '0;
    repeat_seen    = 1'b0;
    closed_events  = '0;
    closed_flagged = '0;

    // Directed: empty event, ID extremes, repeats, late primary, unused code
    push_hit(CMD_CLOSE, 8'd0);
    push_hit(CMD_PRIMARY, 8'd0);
    push_hit(CMD_PRIMARY, 8'd255);
    push_hit(CMD_SECONDARY, 8'd0);
    push_hit(CMD_SECONDARY, 8'd255);
    push_hit(CMD_CLOSE, 8'd255);
    push_hit(CMD_PRIMARY, 8'd7);
    push_hit(CMD_PRIMARY, 8'd7);
    push_hit(CMD_SECONDARY, 8'd7);
    push_hit(CMD_SECONDARY, 8'd7);
    push_hit(CMD_SECONDARY, 8'd7);
    push_hit(CMD_CLOSE, 8'd0);
    push_hit(CMD_SECONDARY, 8'd9);
    push_hit(CMD_PRIMARY, 8'd9);
    push_hit(CMD_SECONDARY, 8'd9);
    push_hit(CMD_CLOSE, 8'd0);
    push_hit(CMD_UNUSED, 8'd170);
    push_hit(CMD_PRIMARY, 8'd85);
    push_hit(CMD_SECONDARY, 8'd85);
    push_hit(CMD_UNUSED, 8'd255);
    push_hit(CMD_CLOSE, 8'd170);

    // Random events, mostly well formed
    items_queued = 0;
    while (items_queued < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 80) queue_clean_event();
      else if (kind < 83) queue_count_ceiling_event();
      else if (kind < 86) queue_extra_ceiling_event();
      else queue_noise();
    end
    push_hit(CMD_CLOSE, 8'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain stimulus, then outstanding results
    while (hit_stream.size() != 0 || start) @(negedge clk);
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_reports.size() != 0) mismatches++;

    $display("Sent %0d commands; checked %0d event reports, %0d with repeated primaries,",
             items_sent, reports_checked, flagged_checked);
    $display("%0d with the extra count at its ceiling; %0d mismatches.",
             saturated_reports, mismatches);
    if (mismatches == 0)
      $display("hit_id_multiset_matcher_core test passed");
    else
      $display("hit_id_multiset_matcher_core test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/himm_pkg.sv
rtl/himm_ctrl.sv
rtl/himm_datapath.sv
rtl/hit_id_multiset_matcher_core.sv
test/hit_id_multiset_matcher_core_tb.sv
